// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant checked at every clock edge outside reset.
`define QCS_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("invariant violated");

// Same-cycle implication.
`define QCS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication violated");

// Next-cycle implication.
`define QCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

// ===== design/qcs_pkg.sv =====
`timescale 1ns / 1ps
package qcs_pkg;

	localparam int MAX_LEN_DEF    = 256;
	localparam int COUNT_BITS_DEF = 14;
	localparam int NUM_BINS       = 128;
	localparam int BIN_W          = 7;
	localparam int CFG_W          = 9;
	localparam int TALLY_W        = 9;
	localparam int REG_IDX_W      = 1;

	localparam logic [TALLY_W-1:0] TALLY_MAX       = 9'd511;
	localparam logic [CFG_W-1:0]   READ_LENGTH_RST = 9'd100;
	localparam logic [CFG_W-1:0]   MATCH_LIMIT_RST = 9'd0;

	localparam logic [REG_IDX_W-1:0] REG_READ_LENGTH = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_MATCH_LIMIT = 1'd1;

	localparam logic [1:0] ACT_SAMPLE  = 2'd0;
	localparam logic [1:0] ACT_COMPUTE = 2'd1;
	localparam logic [1:0] ACT_TEST    = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SAMP_WR,
		ST_TEST_CMP,
		ST_COMPUTE,
		ST_DRAIN,
		ST_CDONE
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic clearing;
		logic walking;
		logic samp_wr;
		logic test_go;
		logic emit_test;
		logic emit_center;
	} ctrl_t;

endpackage

// ===== design/qcs_ram.sv =====
`timescale 1ns / 1ps
module qcs_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 256,
	parameter int ADDR_W = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read-first: a same-cycle write returns the old word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/qcs_ctrl.sv =====
`timescale 1ns / 1ps
module qcs_ctrl #(
	parameter int ADDR_W = 15,
	parameter int DEPTH  = 32768
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        action,
	input  logic              last_q,
	input  logic              out_free,
	output qcs_pkg::ctrl_t    ctl,
	output logic [ADDR_W-1:0] walk
);
	import qcs_pkg::*;

	state_t state_q, state_d;
	logic [ADDR_W-1:0] walk_q;
	logic walk_last;

	assign walk_last = (walk_q == ADDR_W'(DEPTH - 1));
	assign walk = walk_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (walk_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					case (action)
						ACT_SAMPLE:  state_d = ST_SAMP_WR;
						ACT_COMPUTE: state_d = ST_COMPUTE;
						ACT_TEST:    state_d = ST_TEST_CMP;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_SAMP_WR: state_d = ST_IDLE;
			ST_TEST_CMP: begin
				if (!last_q || out_free) state_d = ST_IDLE;
			end
			ST_COMPUTE: begin
				if (walk_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_CDONE;
			ST_CDONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl             = '0;
		ctl.in_ready    = (state_q == ST_IDLE);
		ctl.clearing    = (state_q == ST_CLEAR);
		ctl.walking     = (state_q == ST_COMPUTE);
		ctl.samp_wr     = (state_q == ST_SAMP_WR);
		ctl.test_go     = (state_q == ST_TEST_CMP) && (!last_q || out_free);
		ctl.emit_test   = (state_q == ST_TEST_CMP) && last_q && out_free;
		ctl.emit_center = (state_q == ST_CDONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			walk_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR || state_q == ST_COMPUTE) begin
				walk_q <= walk_last ? '0 : walk_q + ADDR_W'(1);
			end
		end
	end

endmodule

// ===== design/quality_consensus_split.sv =====
`timescale 1ns / 1ps
// Sample beat: histogram read, then saturating write-back.
// Test beat: result registered at the end of the last character.
// Compute beat: walks all MAX_LEN*128 histogram words, one per cycle through the read port.
// Result register lets a new beat enter while a result waits.
// After reset a clearing pass over all MAX_LEN*128 histogram words (32768 by default) zeroes the
// histogram and center store; in_ready stays low meanwhile, config writes are taken.
`include "assert_macros.svh"
module quality_consensus_split #(
	parameter int MAX_LEN    = qcs_pkg::MAX_LEN_DEF,
	parameter int COUNT_BITS = qcs_pkg::COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      action,
	input  logic [qcs_pkg::BIN_W-1:0]       qual,
	input  logic                            last_of_read,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [qcs_pkg::TALLY_W-1:0]     match_count,
	output logic                            similar,
	output logic                            center_ready,
	input  logic                            cfg_we,
	input  logic [qcs_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [qcs_pkg::CFG_W-1:0]       cfg_data
);
	import qcs_pkg::*;

	localparam int COL_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int ADDR_W = COL_W + BIN_W;
	localparam int DEPTH  = MAX_LEN * NUM_BINS;
	localparam int LEN_W  = $clog2(MAX_LEN + 1);
	localparam int CMP_W  = ((LEN_W > CFG_W) ? LEN_W : CFG_W) + 1;

	ctrl_t ctl;
	logic [ADDR_W-1:0] walk;
	logic out_free;

	logic [CFG_W-1:0] read_length_q, match_limit_q;
	logic [BIN_W-1:0] qual_q;
	logic last_q;
	logic [COL_W-1:0] column_pos_q, col_adv;
	logic [TALLY_W-1:0] tally_q, tally_new;

	logic [CMP_W-1:0] rl_ext, eff_len, col_nxt;

	logic hist_we;
	logic [ADDR_W-1:0] hist_waddr, hist_raddr;
	logic [COUNT_BITS-1:0] hist_wdata, hist_rdata, hist_inc;

	logic cs_we;
	logic [COL_W-1:0] cs_waddr;
	logic [BIN_W-1:0] cs_wdata, cs_rdata;

	logic vld_s1;
	logic [BIN_W-1:0] bin_s1;
	logic [COL_W-1:0] col_s1;
	logic [COUNT_BITS-1:0] best_cnt_q, nb_cnt;
	logic [BIN_W-1:0] best_bin_q, nb_bin;
	logic take_new;

	logic out_valid_q, similar_q, center_ready_q;
	logic [TALLY_W-1:0] match_count_q;

	qcs_ctrl #(
		.ADDR_W(ADDR_W),
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.action  (action),
		.last_q  (last_q),
		.out_free(out_free),
		.ctl     (ctl),
		.walk    (walk)
	);

	assign in_ready = ctl.in_ready;
	assign out_free = !out_valid_q || out_ready;

	// column wrap against the clamped read length
	assign rl_ext  = CMP_W'(read_length_q);
	assign eff_len = (rl_ext == '0) ? CMP_W'(1) :
	                 (rl_ext > CMP_W'(MAX_LEN)) ? CMP_W'(MAX_LEN) : rl_ext;
	assign col_nxt = CMP_W'(column_pos_q) + CMP_W'(1);
	assign col_adv = (col_nxt >= eff_len) ? '0 : COL_W'(col_nxt);

	assign tally_new = ((cs_rdata == qual_q) && (tally_q != TALLY_MAX)) ?
	                   tally_q + TALLY_W'(1) : tally_q;

	// histogram: clear/compute sweeps zero the walked word, samples write back +1
	assign hist_inc   = (hist_rdata == '1) ? hist_rdata : hist_rdata + COUNT_BITS'(1);
	assign hist_we    = ctl.clearing || ctl.walking || ctl.samp_wr;
	assign hist_waddr = ctl.samp_wr ? {column_pos_q, qual_q} : walk;
	assign hist_wdata = ctl.samp_wr ? hist_inc : '0;
	assign hist_raddr = ctl.walking ? walk : {column_pos_q, qual};

	qcs_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (DEPTH),
		.ADDR_W(ADDR_W)
	) u_hist (
		.clk  (clk),
		.we   (hist_we),
		.waddr(hist_waddr),
		.wdata(hist_wdata),
		.raddr(hist_raddr),
		.rdata(hist_rdata)
	);

	// running max over a column; bin 0 seeds it, strict > keeps the lowest code
	assign take_new = (bin_s1 == '0) || (hist_rdata > best_cnt_q);
	assign nb_cnt   = take_new ? hist_rdata : best_cnt_q;
	assign nb_bin   = take_new ? bin_s1 : best_bin_q;

	assign cs_we    = ctl.clearing || (vld_s1 && (bin_s1 == BIN_W'(NUM_BINS - 1)));
	assign cs_waddr = ctl.clearing ? walk[ADDR_W-1:BIN_W] : col_s1;
	assign cs_wdata = ctl.clearing ? '0 : nb_bin;

	qcs_ram #(
		.WIDTH (BIN_W),
		.DEPTH (MAX_LEN),
		.ADDR_W(COL_W)
	) u_center (
		.clk  (clk),
		.we   (cs_we),
		.waddr(cs_waddr),
		.wdata(cs_wdata),
		.raddr(column_pos_q),
		.rdata(cs_rdata)
	);

	always_ff @(posedge clk) begin
		if (in_valid && ctl.in_ready) begin
			qual_q <= qual;
			last_q <= last_of_read;
		end
		bin_s1 <= walk[BIN_W-1:0];
		col_s1 <= walk[ADDR_W-1:BIN_W];
		if (vld_s1) begin
			best_cnt_q <= nb_cnt;
			best_bin_q <= nb_bin;
		end
		if (ctl.emit_test) begin
			match_count_q  <= tally_new;
			similar_q      <= (tally_new > match_limit_q);
			center_ready_q <= 1'b0;
		end else if (ctl.emit_center) begin
			match_count_q  <= '0;
			similar_q      <= 1'b0;
			center_ready_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_length_q <= READ_LENGTH_RST;
			match_limit_q <= MATCH_LIMIT_RST;
			column_pos_q  <= '0;
			tally_q       <= '0;
			vld_s1        <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_READ_LENGTH: read_length_q <= cfg_data;
					REG_MATCH_LIMIT: match_limit_q <= cfg_data;
					default: ;
				endcase
			end
			vld_s1 <= ctl.walking;
			if (ctl.samp_wr) begin
				column_pos_q <= last_q ? '0 : col_adv;
			end else if (ctl.test_go) begin
				column_pos_q <= last_q ? '0 : col_adv;
				tally_q      <= last_q ? '0 : tally_new;
			end else if (ctl.emit_center) begin
				column_pos_q <= '0;
				tally_q      <= '0;
			end
			if (ctl.emit_test || ctl.emit_center) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign match_count  = match_count_q;
	assign similar      = similar_q;
	assign center_ready = center_ready_q;

	`QCS_ASSERT_ALWAYS(a_col_bound, clk, arst_n, CMP_W'(column_pos_q) < eff_len)
	`QCS_ASSERT_IMPL(a_center_beat, clk, arst_n, out_valid_q && center_ready_q, match_count_q == '0 && !similar_q)
	`QCS_ASSERT_IMPL(a_similar, clk, arst_n, out_valid_q && !center_ready_q, similar_q == (match_count_q > match_limit_q))
	`QCS_ASSERT_NEXT(a_compute_busy, clk, arst_n, in_valid && ctl.in_ready && action == ACT_COMPUTE, !ctl.in_ready)

endmodule
